@@ hdl/euler_vertex_rotator_defines.svh @@
// Assertion macros for the euler_vertex_rotator checker.
// No dependencies; included by evr_checker.sv.
`ifndef EULER_VERTEX_ROTATOR_DEFINES_SVH
`define EULER_VERTEX_ROTATOR_DEFINES_SVH

// Clocked assertion, aborted while reset is active
`define EVR_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset
`define EVR_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/evr_pkg.sv @@
// Package for the Euler vertex rotator: coordinate and coefficient types,
// register indexes, plane codes and the saturation helper. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package evr_pkg;

    localparam int COORD_W = 32;                 // Q16.16 coordinate
    localparam int COEF_W  = 16;                 // Q2.14 coefficient
    localparam int FRAC    = 14;                 // coefficient fraction bits
    localparam int PROD_W  = COORD_W + COEF_W;   // one product
    localparam int SUM_W   = PROD_W + 1;         // sum or difference of two products
    localparam int SHR_W   = SUM_W - FRAC;       // sum after dropping the fraction
    localparam int ADDR_W  = 3;                  // register index width

    localparam logic signed [COEF_W-1:0] COEF_ONE  = COEF_W'(16384);
    localparam logic signed [COEF_W-1:0] COEF_ZERO = '0;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [COEF_W-1:0]  coef_t;
    typedef logic signed [PROD_W-1:0]  prod_t;

    // Configuration register indexes
    typedef enum logic [ADDR_W-1:0] {
        REG_COS_PITCH = 3'd0,
        REG_SIN_PITCH = 3'd1,
        REG_COS_YAW   = 3'd2,
        REG_SIN_YAW   = 3'd3,
        REG_COS_ROLL  = 3'd4,
        REG_SIN_ROLL  = 3'd5,
        REG_ROT_ORDER = 3'd6
    } reg_idx_t;

    // Rotation order codes
    localparam logic ORDER_YAW_FIRST   = 1'b0;
    localparam logic ORDER_PITCH_FIRST = 1'b1;

    // Which coordinate pair a stage rotates
    typedef enum logic [1:0] {
        PLANE_XY = 2'd0,   // roll
        PLANE_XZ = 2'd1,   // yaw
        PLANE_YZ = 2'd2    // pitch
    } plane_t;

    typedef struct packed {
        coef_t cos_pitch;
        coef_t sin_pitch;
        coef_t cos_yaw;
        coef_t sin_yaw;
        coef_t cos_roll;
        coef_t sin_roll;
        logic  rotation_order;
    } cfg_t;

    typedef struct packed {
        coord_t in_x;
        coord_t in_y;
        coord_t in_z;
    } vertex_in_t;

    typedef struct packed {
        coord_t out_x;
        coord_t out_y;
        coord_t out_z;
    } vertex_out_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } vec_t;

    // Clamp a shifted sum to the signed coordinate range
    function automatic coord_t sat_coord(input logic [SHR_W-1:0] v);
        logic [SHR_W-COORD_W:0] top;
        top = v[SHR_W-1:COORD_W-1];
        if ((&top) || !(|top))
            return coord_t'(v[COORD_W-1:0]);
        else if (v[SHR_W-1])
            return coord_t'({1'b1, {(COORD_W-1){1'b0}}});
        else
            return coord_t'({1'b0, {(COORD_W-1){1'b1}}});
    endfunction

endpackage

`default_nettype wire

@@ hdl/evr_cfg_regs.sv @@
// Configuration register file: trig coefficients and rotation order.
// Depends on evr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module evr_cfg_regs
    import evr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [ADDR_W-1:0] cfg_addr,
    input  wire logic [COEF_W-1:0] cfg_wdata,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write; indexes past the list are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (reg_idx_t'(cfg_addr))
                REG_COS_PITCH: cfg_next.cos_pitch      = coef_t'(cfg_wdata);
                REG_SIN_PITCH: cfg_next.sin_pitch      = coef_t'(cfg_wdata);
                REG_COS_YAW:   cfg_next.cos_yaw        = coef_t'(cfg_wdata);
                REG_SIN_YAW:   cfg_next.sin_yaw        = coef_t'(cfg_wdata);
                REG_COS_ROLL:  cfg_next.cos_roll       = coef_t'(cfg_wdata);
                REG_SIN_ROLL:  cfg_next.sin_roll       = coef_t'(cfg_wdata);
                REG_ROT_ORDER: cfg_next.rotation_order = cfg_wdata[0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    // Reset to the identity rotation
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cos_pitch      <= COEF_ONE;
            cfg_reg.sin_pitch      <= COEF_ZERO;
            cfg_reg.cos_yaw        <= COEF_ONE;
            cfg_reg.sin_yaw        <= COEF_ZERO;
            cfg_reg.cos_roll       <= COEF_ONE;
            cfg_reg.sin_roll       <= COEF_ZERO;
            cfg_reg.rotation_order <= ORDER_YAW_FIRST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ hdl/evr_plane_rot.sv @@
// One plane rotation, two pipeline stages: products, then sum/shift/saturate.
// Depends on evr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module evr_plane_rot
    import evr_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   in_valid,
    input  wire vec_t   in_vec,
    input  wire plane_t plane,
    input  wire coef_t  c,
    input  wire coef_t  s,
    output logic        out_valid,
    output vec_t        out_vec
);

    // Stage A registers
    logic   valid_a_reg;
    vec_t   vec_a_reg;
    plane_t plane_a_reg;
    prod_t  pc_reg, qs_reg, ps_reg, qc_reg;

    // Stage B registers
    logic   valid_b_reg;
    vec_t   vec_b_reg;

    coord_t p, q;
    prod_t  pc_next, qs_next, ps_next, qc_next;

    logic signed [SUM_W-1:0] np_sum, nq_sum, np_sh, nq_sh;
    coord_t                  np_sat, nq_sat;
    vec_t                    vec_b_next;

    // Pick the pair being rotated
    always_comb
    begin
        case (plane)
            PLANE_XY:
            begin
                p = in_vec.x;
                q = in_vec.y;
            end
            PLANE_XZ:
            begin
                p = in_vec.x;
                q = in_vec.z;
            end
            PLANE_YZ:
            begin
                p = in_vec.y;
                q = in_vec.z;
            end
            default:
            begin
                p = in_vec.x;
                q = in_vec.y;
            end
        endcase
    end

    // Four 32x16 signed products
    assign pc_next = p * c;
    assign qs_next = q * s;
    assign ps_next = p * s;
    assign qc_next = q * c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_a_reg <= 1'b0;
        else
            valid_a_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        vec_a_reg   <= in_vec;
        plane_a_reg <= plane;
        pc_reg      <= pc_next;
        qs_reg      <= qs_next;
        ps_reg      <= ps_next;
        qc_reg      <= qc_next;
    end

    // Exact sums, floor shift, clamp
    assign np_sum = SUM_W'(pc_reg) - SUM_W'(qs_reg);
    assign nq_sum = SUM_W'(ps_reg) + SUM_W'(qc_reg);
    assign np_sh  = np_sum >>> FRAC;
    assign nq_sh  = nq_sum >>> FRAC;
    assign np_sat = sat_coord(np_sh[SHR_W-1:0]);
    assign nq_sat = sat_coord(nq_sh[SHR_W-1:0]);

    // Put the rotated pair back in place
    always_comb
    begin
        vec_b_next = vec_a_reg;
        case (plane_a_reg)
            PLANE_XY:
            begin
                vec_b_next.x = np_sat;
                vec_b_next.y = nq_sat;
            end
            PLANE_XZ:
            begin
                vec_b_next.x = np_sat;
                vec_b_next.z = nq_sat;
            end
            PLANE_YZ:
            begin
                vec_b_next.y = np_sat;
                vec_b_next.z = nq_sat;
            end
            default:
            begin
                vec_b_next = vec_a_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_b_reg <= 1'b0;
        else
            valid_b_reg <= valid_a_reg;
    end

    always_ff @(posedge clk)
    begin
        vec_b_reg <= vec_b_next;
    end

    assign out_valid = valid_b_reg;
    assign out_vec   = vec_b_reg;

endmodule

`default_nettype wire

@@ hdl/euler_vertex_rotator.sv @@
// Top level of the Euler vertex rotator: register file and three plane rotations.
// Depends on evr_pkg, evr_cfg_regs and evr_plane_rot.
//
//  channel   handshake            payload               width
//  input     start & !busy        vertex (vertex_in_t)  3 x 32
//  result    done (one cycle)     result (vertex_out_t) 3 x 32
//  config    cfg_we               cfg_addr, cfg_wdata   3, 16
//
// One vertex per cycle while busy is low; each plane rotation has a multiply
// stage and then a sum/shift/saturate stage, both registered.
// busy is high only in reset and the cycle after; then every cycle accepts.
// The result sits on result for the single cycle that done is high.
// Reset clears the valid bits and loads the identity rotation.
`timescale 1ns / 1ps
`default_nettype none

module euler_vertex_rotator
    import evr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire vertex_in_t        vertex,
    input  wire logic              cfg_we,
    input  wire logic [ADDR_W-1:0] cfg_addr,
    input  wire logic [COEF_W-1:0] cfg_wdata,
    output logic                   done,
    output vertex_out_t            result
);

    cfg_t   cfg;
    logic   busy_reg;
    logic   busy_next;
    logic   accept;
    vec_t   vec_in;
    plane_t plane1, plane2;
    coef_t  c1, s1, c2, s2;
    logic   v1, v2, v3;
    vec_t   vec1, vec2, vec3;

    evr_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Busy holds off transactions until reset has been released
    assign busy_next = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b1;
        else
            busy_reg <= busy_next;
    end

    assign busy   = busy_reg;
    assign accept = start && !busy_reg;

    assign vec_in.x = vertex.in_x;
    assign vec_in.y = vertex.in_y;
    assign vec_in.z = vertex.in_z;

    // First two rotations follow the order register; roll is always last
    always_comb
    begin
        if (cfg.rotation_order == ORDER_PITCH_FIRST)
        begin
            plane1 = PLANE_YZ;
            c1     = cfg.cos_pitch;
            s1     = cfg.sin_pitch;
            plane2 = PLANE_XZ;
            c2     = cfg.cos_yaw;
            s2     = cfg.sin_yaw;
        end
        else
        begin
            plane1 = PLANE_XZ;
            c1     = cfg.cos_yaw;
            s1     = cfg.sin_yaw;
            plane2 = PLANE_YZ;
            c2     = cfg.cos_pitch;
            s2     = cfg.sin_pitch;
        end
    end

    evr_plane_rot u_rot1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .in_vec    (vec_in),
        .plane     (plane1),
        .c         (c1),
        .s         (s1),
        .out_valid (v1),
        .out_vec   (vec1)
    );

    evr_plane_rot u_rot2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v1),
        .in_vec    (vec1),
        .plane     (plane2),
        .c         (c2),
        .s         (s2),
        .out_valid (v2),
        .out_vec   (vec2)
    );

    evr_plane_rot u_rot3 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v2),
        .in_vec    (vec2),
        .plane     (PLANE_XY),
        .c         (cfg.cos_roll),
        .s         (cfg.sin_roll),
        .out_valid (v3),
        .out_vec   (vec3)
    );

    // Last stage register drives the result port
    assign done         = v3;
    assign result.out_x = vec3.x;
    assign result.out_y = vec3.y;
    assign result.out_z = vec3.z;

endmodule

`default_nettype wire

@@ hdl/evr_checker.sv @@
// Port-level checker for euler_vertex_rotator, bound to the top level.
// Depends on euler_vertex_rotator_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "euler_vertex_rotator_defines.svh"

module evr_checker
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic done
);

    // Every accepted transaction comes out as a done strobe
    `EVR_ASSERT_RST(a_latency, (start && !busy) |-> ##6 done, "accepted vertex gave no result")

    // No result without an earlier accepted transaction
    `EVR_ASSERT_RST(a_no_phantom, done |-> $past(start && !busy, 6), "result without a vertex")

    // Once out of reset the block never refuses a transaction
    `EVR_ASSERT_RST(a_never_busy, $past(rst_n) |-> !busy, "busy after reset release")

    // No result during reset
    `EVR_ASSERT_CLK(a_reset_quiet, !rst_n |-> !done, "result strobe during reset")

endmodule

bind euler_vertex_rotator evr_checker u_evr_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);

`default_nettype wire
